// ===== design/lha_pkg.sv =====
// Shared types and constants for the luma histogram auto levels block.
package lha_pkg;

    localparam int LUMA_W     = 8;
    localparam int BINS       = 256;
    localparam int THR_W      = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [LUMA_W-1:0] LUMA_MAX = LUMA_W'(BINS - 1);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_REMAP_ENABLE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_ENABLE       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REMAP_LOW         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REMAP_HIGH        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_PERCENT = 3'd4;

    // Register values seen by the level search
    typedef struct packed {
        logic              remap_enable;
        logic              auto_enable;
        logic [LUMA_W-1:0] remap_low;
        logic [LUMA_W-1:0] remap_high;
        logic [THR_W-1:0]  threshold_percent;
    } scan_cfg_t;

    // Frame control toward the histogram store
    typedef struct packed {
        logic              pix_valid;
        logic [LUMA_W-1:0] luma;
        logic              clear_start;
    } hist_ctrl_t;

endpackage

// ===== design/luma_histogram_auto_levels_core.sv =====
// Top level of the luma histogram auto levels block: ports, registers and frame control.
//
// Input stream: one 8-bit luma sample per request on s_tdata[7:0], s_tlast on the
// final sample of a frame. Samples are taken one per cycle for the whole frame;
// each one bumps its bin in a 256-entry memory through a registered
// read-modify-write with forwarding, so repeated values back to back are fine.
// Output stream: one request per frame on m_tdata, low level in [7:0], high
// level in [15:8]. After the last sample the block runs a setup step, then,
// with the search on, an upward scan and a downward scan (one bin a cycle
// through the memory read port), and then loads the output register.
// The result waits in the output register while m_tready is low; a later result
// waits in the search until that register frees up. Once a result is loaded the
// bins are swept to zero and s_tready rises after the sweep, so s_tready is low
// from the last sample until then. Reset runs the same clear before s_tready
// rises.
// Configuration: cfg_we with cfg_addr/cfg_wdata writes one register; write only
// while no frame is in progress.
module luma_histogram_auto_levels_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] luma
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [7:0] level_low, [15:8] level_high
    input  logic                              cfg_we,
    input  logic [lha_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lha_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import lha_pkg::*;

    localparam logic [1:0] F_CLEAR = 2'd0;
    localparam logic [1:0] F_IDLE  = 2'd1;
    localparam logic [1:0] F_SCAN  = 2'd2;

    logic [1:0]             fstate_reg, fstate_next;
    scan_cfg_t              cfg_reg,    cfg_next;

    hist_ctrl_t             hist_ctrl;
    logic                   pix_accept;
    logic                   scan_start;
    logic                   scan_done;
    logic                   clear_busy;
    logic [LUMA_W-1:0]      scan_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] pixel_count;
    logic [LUMA_W-1:0]      level_low;
    logic [LUMA_W-1:0]      level_high;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_REMAP_ENABLE:      cfg_next.remap_enable      = cfg_wdata[0];
                REG_AUTO_ENABLE:       cfg_next.auto_enable       = cfg_wdata[0];
                REG_REMAP_LOW:         cfg_next.remap_low         = cfg_wdata[LUMA_W-1:0];
                REG_REMAP_HIGH:        cfg_next.remap_high        = cfg_wdata[LUMA_W-1:0];
                REG_THRESHOLD_PERCENT: cfg_next.threshold_percent = cfg_wdata[THR_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.remap_enable      <= 1'b0;
            cfg_reg.auto_enable       <= 1'b0;
            cfg_reg.remap_low         <= '0;
            cfg_reg.remap_high        <= LUMA_MAX;
            cfg_reg.threshold_percent <= THR_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Frame control: clear, take samples, search
    assign s_tready   = (fstate_reg == F_IDLE);
    assign pix_accept = s_tvalid && s_tready;
    assign scan_start = pix_accept && s_tlast;

    assign hist_ctrl.pix_valid   = pix_accept;
    assign hist_ctrl.luma        = s_tdata[LUMA_W-1:0];
    assign hist_ctrl.clear_start = scan_done;

    always_comb
    begin
        fstate_next = fstate_reg;
        unique case (fstate_reg)
            F_CLEAR:
            begin
                if (!clear_busy)
                begin
                    fstate_next = F_IDLE;
                end
            end
            F_IDLE:
            begin
                if (scan_start)
                begin
                    fstate_next = F_SCAN;
                end
            end
            F_SCAN:
            begin
                if (scan_done)
                begin
                    fstate_next = F_CLEAR;
                end
            end
            default:
            begin
                fstate_next = F_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg <= F_CLEAR;
        end
        else
        begin
            fstate_reg <= fstate_next;
        end
    end

    lha_hist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (hist_ctrl),
        .scan_addr   (scan_addr),
        .rd_data     (rd_data),
        .pixel_count (pixel_count),
        .clear_busy  (clear_busy)
    );

    lha_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .cfg         (cfg_reg),
        .pixel_count (pixel_count),
        .rd_data     (rd_data),
        .scan_addr   (scan_addr),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .level_low   (level_low),
        .level_high  (level_high),
        .done        (scan_done)
    );

    assign m_tdata = {level_high, level_low};

endmodule

// ===== design/lha_hist.sv =====
// Histogram store: bin memory, per-pixel read-modify-write, pixel count and clear sweep.
module lha_hist #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lha_pkg::hist_ctrl_t          ctrl,
    input  logic [lha_pkg::LUMA_W-1:0]   scan_addr,
    output logic [COUNT_WIDTH-1:0]       rd_data,
    output logic [COUNT_WIDTH-1:0]       pixel_count,
    output logic                         clear_busy
);
    import lha_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [0:BINS-1];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    logic                   s1_valid_reg;
    logic [LUMA_W-1:0]      s1_luma_reg;
    logic                   wb_valid_reg;
    logic [LUMA_W-1:0]      wb_addr_reg;
    logic [COUNT_WIDTH-1:0] wb_data_reg;

    logic                   clr_busy_reg;
    logic [LUMA_W-1:0]      clr_addr_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    logic [LUMA_W-1:0]      rd_addr;
    logic [COUNT_WIDTH-1:0] bin_cur;
    logic [COUNT_WIDTH-1:0] bin_next;
    logic                   wr_en;
    logic [LUMA_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    // Pixel lookups take the read port; the level search uses it between frames
    assign rd_addr = ctrl.pix_valid ? ctrl.luma : scan_addr;

    // Bin written last cycle is not yet visible in the read data
    assign bin_cur  = (wb_valid_reg && (wb_addr_reg == s1_luma_reg)) ? wb_data_reg : rd_data_reg;
    assign bin_next = (&bin_cur) ? bin_cur : bin_cur + COUNT_WIDTH'(1);

    // Write port: clear sweep or bin update, never both
    assign wr_en   = clr_busy_reg || s1_valid_reg;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : s1_luma_reg;
    assign wr_data = clr_busy_reg ? '0 : bin_next;

    // Bin memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Update stage and forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.pix_valid;
            wb_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_luma_reg <= ctrl.luma;
        wb_addr_reg <= s1_luma_reg;
        wb_data_reg <= bin_next;
    end

    // Clear sweep, one bin per cycle; also runs out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (ctrl.clear_start)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + LUMA_W'(1);
            if (clr_addr_reg == LUMA_MAX)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Saturating pixel count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear_start)
        begin
            count_next = '0;
        end
        else if (ctrl.pix_valid && !(&count_reg))
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_data     = rd_data_reg;
    assign pixel_count = count_reg;
    assign clear_busy  = clr_busy_reg;

`ifndef NO_ASSERTIONS
    a_no_update_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_busy_reg && s1_valid_reg))
        else $error("bin update collides with clear sweep");

    a_clear_covers_all_bins: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> ($past(clr_addr_reg) == LUMA_MAX))
        else $error("clear sweep ended early");

    a_count_drops_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < $past(count_reg)) |-> $past(ctrl.clear_start))
        else $error("pixel count dropped without a clear");

    a_no_pixel_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !ctrl.pix_valid)
        else $error("pixel accepted while clearing");
`endif

endmodule

// ===== design/lha_scan.sv =====
// Level search: cumulative scans over the bin memory and the result register.
module lha_scan #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lha_pkg::scan_cfg_t           cfg,
    input  logic [COUNT_WIDTH-1:0]       pixel_count,
    input  logic [COUNT_WIDTH-1:0]       rd_data,
    output logic [lha_pkg::LUMA_W-1:0]   scan_addr,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lha_pkg::LUMA_W-1:0]   level_low,
    output logic [lha_pkg::LUMA_W-1:0]   level_high,
    output logic                         done
);
    import lha_pkg::*;

    // acc*100 needs 8 bits for 256 bins plus 7 for the factor
    localparam int ACC_W = COUNT_WIDTH + 15;
    localparam int LIM_W = COUNT_WIDTH + THR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_LO    = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        state_reg,     state_next;
    logic [LUMA_W-1:0] lo_reg,        lo_next;
    logic [LUMA_W-1:0] hi_reg,        hi_next;
    logic [LUMA_W-1:0] addr_reg,      addr_next;
    logic [LUMA_W-1:0] ev_addr_reg,   ev_addr_next;
    logic              ev_valid_reg,  ev_valid_next;
    logic              issue_reg,     issue_next;
    logic [ACC_W-1:0]  acc_reg,       acc_next;
    logic [LIM_W-1:0]  limit_reg,     limit_next;
    logic              out_valid_reg, out_valid_next;
    logic [LUMA_W-1:0] out_lo_reg,    out_lo_next;
    logic [LUMA_W-1:0] out_hi_reg,    out_hi_next;

    logic [ACC_W-1:0]  d100;
    logic [ACC_W-1:0]  acc_sum;
    logic              pass;
    logic [LUMA_W-1:0] lo_fin;
    logic [LUMA_W-1:0] hi_stop;
    logic              slot_free;

    // Bin times 100 as shifted adds, then the running sum and the limit test
    assign d100    = (ACC_W'(rd_data) << 6) + (ACC_W'(rd_data) << 5) + (ACC_W'(rd_data) << 2);
    assign acc_sum = acc_reg + d100;
    assign pass    = (acc_sum <= ACC_W'(limit_reg));
    assign lo_fin  = pass ? ev_addr_reg : lo_reg;
    assign hi_stop = lo_reg + LUMA_W'(1);
    assign slot_free = !out_valid_reg || m_tready;

    // Sequencer: one read issued per cycle, its bin evaluated the next
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        addr_next      = addr_reg;
        ev_addr_next   = ev_addr_reg;
        ev_valid_next  = 1'b0;
        issue_next     = issue_reg;
        acc_next       = acc_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        done           = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                lo_next    = cfg.remap_enable ? cfg.remap_low  : '0;
                hi_next    = cfg.remap_enable ? cfg.remap_high : LUMA_MAX;
                limit_next = LIM_W'(cfg.threshold_percent) * LIM_W'(pixel_count);
                acc_next   = '0;
                addr_next  = lo_next;
                issue_next = 1'b0;
                if (cfg.auto_enable && (pixel_count != '0))
                begin
                    issue_next = 1'b1;
                    state_next = S_LO;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_LO:
            begin
                ev_valid_next = issue_reg;
                ev_addr_next  = addr_reg;
                if (issue_reg)
                begin
                    addr_next  = addr_reg + LUMA_W'(1);
                    issue_next = (addr_reg != LUMA_MAX);
                end
                if (ev_valid_reg && pass)
                begin
                    lo_next  = ev_addr_reg;
                    acc_next = acc_sum;
                end
                // Low level settled: restart from the high start
                if (ev_valid_reg && (!pass || (ev_addr_reg == LUMA_MAX)))
                begin
                    acc_next      = '0;
                    ev_valid_next = 1'b0;
                    addr_next     = hi_reg;
                    if (hi_reg > lo_fin)
                    begin
                        issue_next = 1'b1;
                        state_next = S_HI;
                    end
                    else
                    begin
                        issue_next = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_HI:
            begin
                ev_valid_next = issue_reg;
                ev_addr_next  = addr_reg;
                if (issue_reg)
                begin
                    addr_next  = addr_reg - LUMA_W'(1);
                    issue_next = (addr_reg != hi_stop);
                end
                if (ev_valid_reg && pass)
                begin
                    hi_next  = ev_addr_reg;
                    acc_next = acc_sum;
                end
                if (ev_valid_reg && (!pass || (ev_addr_reg == hi_stop)))
                begin
                    ev_valid_next = 1'b0;
                    issue_next    = 1'b0;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_lo_next    = lo_reg;
                    out_hi_next    = hi_reg;
                    done           = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ev_valid_reg  <= 1'b0;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ev_valid_reg  <= ev_valid_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        addr_reg    <= addr_next;
        ev_addr_reg <= ev_addr_next;
        acc_reg     <= acc_next;
        limit_reg   <= limit_next;
        out_lo_reg  <= out_lo_next;
        out_hi_reg  <= out_hi_next;
    end

    assign scan_addr  = addr_reg;
    assign m_tvalid   = out_valid_reg;
    assign level_low  = out_lo_reg;
    assign level_high = out_hi_reg;

`ifndef NO_ASSERTIONS
    a_eval_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> ((state_reg == S_LO) || (state_reg == S_HI)))
        else $error("bin evaluated outside a scan");

    a_high_scan_above_low: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_HI) && ev_valid_reg) |-> (ev_addr_reg > lo_reg))
        else $error("high scan reached the low level");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("frame end while search still running");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result raised outside emit");
`endif

endmodule

// ===== tb/luma_histogram_auto_levels_core_test.sv =====
// Self-checking testbench for the luma histogram auto levels core.
`timescale 1ns / 1ps

module luma_histogram_auto_levels_core_test;
    import lha_pkg::*;

    localparam int COUNT_W       = 24;
    localparam int CLK_HALF      = 6;
    localparam int GAP_PCT       = 7;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 600;
    localparam int PHASE_PIXELS  = 90;
    localparam int RANDOM_PHASES = 8;
    localparam int LIMIT_CYCLES  = 1_000_000;

    localparam logic [COUNT_W-1:0]    CNT_MAX   = '1;
    // Index past the register list, must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic              last;
    } pixel_t;

    typedef struct packed {
        logic [LUMA_W-1:0] low;
        logic [LUMA_W-1:0] high;
    } levels_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: shadow registers, bins and frame pixel count
    scan_cfg_t             cfg_shadow;
    logic [COUNT_W-1:0]    bin_count [BINS];
    logic [COUNT_W-1:0]    frame_pixels;
    levels_t               levels_due [$];

    pixel_t                pixel_feed [$];
    pixel_t                pix_cur;
    bit                    src_busy;
    bit                    gaps_on     = 1'b1;
    bit                    hold_req    = 1'b0;
    int                    hold_left   = 0;
    int                    frames_queued  = 0;
    int                    levels_checked = 0;
    int                    pixels_sent    = 0;
    int                    cfg_settings   = 0;
    int                    fail_count     = 0;

    luma_histogram_auto_levels_core #(
        .COUNT_WIDTH(COUNT_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Timeout at %0t: %0d of %0d frame results seen",
                 $time, levels_checked, frames_queued);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic clear_bins();
        for (int b = 0; b < BINS; b++)
            bin_count[b] = '0;
        frame_pixels = '0;
    endtask

    // Histogram update per pixel; at frame end, the percentile level search
    task automatic tally_pixel(input pixel_t px);
        int               lo;
        int               hi;
        int               i;
        longint unsigned  limit;
        longint unsigned  acc;
        levels_t          lv;
        if (bin_count[px.luma] != CNT_MAX)
            bin_count[px.luma] = bin_count[px.luma] + 1'b1;
        if (frame_pixels != CNT_MAX)
            frame_pixels = frame_pixels + 1'b1;
        pixels_sent++;
        if (px.last)
        begin
            lo = 0;
            hi = 255;
            if (cfg_shadow.remap_enable)
            begin
                lo = int'(cfg_shadow.remap_low);
                hi = int'(cfg_shadow.remap_high);
            end
            if (cfg_shadow.auto_enable && frame_pixels != 0)
            begin
                limit = 64'(frame_pixels) * 64'(cfg_shadow.threshold_percent);
                acc = 0;
                // climb the black level while the cut share stays in bounds
                for (i = lo; i < BINS; i++)
                begin
                    acc += 64'(bin_count[i]);
                    if (acc * 100 > limit)
                        break;
                    lo = i;
                end
                // same from the top, never reaching the black level
                acc = 0;
                for (i = hi; i > lo; i--)
                begin
                    acc += 64'(bin_count[i % BINS]);
                    if (acc * 100 > limit)
                        break;
                    hi = i;
                end
            end
            lv.low  = lo[LUMA_W-1:0];
            lv.high = hi[LUMA_W-1:0];
            levels_due = {levels_due, lv};
            clear_bins();
        end
    endtask

    // Sample source: presents queued pixels, random gaps when enabled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            src_busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                tally_pixel(pix_cur);
                src_busy = 1'b0;
            end
            if (!src_busy)
            begin
                if (pixel_feed.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT))
                begin
                    pix_cur = pixel_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pix_cur.luma;
                    s_tlast  <= pix_cur.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Level sink: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
        end
    end

    // Result check against the oldest expected levels
    always @(posedge clk)
    begin
        levels_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (levels_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual low %0d high %0d",
                         $time, m_tdata[7:0], m_tdata[15:8]);
                fail_count++;
            end
            else
            begin
                want = levels_due.pop_front();
                if (m_tdata[7:0] !== want.low)
                begin
                    $display("%0t: level_low mismatch, expected %0d, actual %0d",
                             $time, want.low, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.high)
                begin
                    $display("%0t: level_high mismatch, expected %0d, actual %0d",
                             $time, want.high, m_tdata[15:8]);
                    fail_count++;
                end
            end
            levels_checked++;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_REMAP_ENABLE:      cfg_shadow.remap_enable      = data[0];
            REG_AUTO_ENABLE:       cfg_shadow.auto_enable       = data[0];
            REG_REMAP_LOW:         cfg_shadow.remap_low         = data;
            REG_REMAP_HIGH:        cfg_shadow.remap_high        = data;
            REG_THRESHOLD_PERCENT: cfg_shadow.threshold_percent = data[THR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_levels_cfg(input bit remap_en, input bit auto_en,
                                  input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [6:0] thr);
        write_reg(REG_REMAP_ENABLE, {7'd0, remap_en});
        write_reg(REG_AUTO_ENABLE, {7'd0, auto_en});
        write_reg(REG_REMAP_LOW, lo);
        write_reg(REG_REMAP_HIGH, hi);
        write_reg(REG_THRESHOLD_PERCENT, {1'b0, thr});
        cfg_settings++;
    endtask

    task automatic push_pixel(input int luma, input bit last);
        pixel_t px;
        px.luma = luma[LUMA_W-1:0];
        px.last = last;
        pixel_feed = {pixel_feed, px};
        if (last)
            frames_queued++;
    endtask

    // Frame of random size and shape: flat, clustered, or piled at the extremes
    task automatic push_random_frame(output int npix);
        int shape;
        int center;
        int spread;
        int v;
        npix   = ($urandom_range(7) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
        shape  = $urandom_range(2);
        center = $urandom_range(255);
        spread = $urandom_range(40, 1);
        for (int k = 0; k < npix; k++)
        begin
            case (shape)
                0: v = $urandom_range(255);
                1: v = center + int'($urandom_range(2 * spread)) - spread;
                default:
                    if ($urandom_range(3) == 0)
                        v = $urandom_range(255);
                    else
                        v = $urandom_range(1) ? 255 : 0;
            endcase
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            push_pixel(v, k == npix - 1);
        end
    endtask

    task automatic random_cfg();
        logic [7:0] lo;
        logic [7:0] hi;
        logic [6:0] thr;
        case ($urandom_range(3))
            0: lo = 8'd0;
            1: lo = 8'd255;
            default: lo = 8'($urandom_range(127));
        endcase
        case ($urandom_range(3))
            0: hi = 8'd255;
            1: hi = 8'd0;
            default: hi = 8'($urandom_range(255, 128));
        endcase
        case ($urandom_range(4))
            0: thr = 7'd0;
            1: thr = 7'd127;
            2: thr = 7'd100;
            3: thr = 7'($urandom_range(127));
            default: thr = 7'($urandom_range(30));
        endcase
        set_levels_cfg(1'($urandom_range(1)), $urandom_range(3) != 0, lo, hi, thr);
    endtask

    // Wait for every queued frame's levels, then let the bin sweep finish
    task automatic drain_frames();
        while (levels_checked < frames_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int npix;
        int phase_pix;
        cfg_shadow.remap_enable      = 1'b0;
        cfg_shadow.auto_enable       = 1'b0;
        cfg_shadow.remap_low         = 8'd0;
        cfg_shadow.remap_high        = 8'd255;
        cfg_shadow.threshold_percent = 7'd1;
        clear_bins();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: start levels pass through
        push_pixel(0, 1'b1);
        push_pixel(255, 1'b0);
        push_pixel(8'hAA, 1'b0);
        push_pixel(8'h55, 1'b1);
        drain_frames();

        // threshold above 100: low scan runs to the top, high scan is empty
        set_levels_cfg(1'b1, 1'b1, 8'd0, 8'd255, 7'd127);
        write_reg(REG_SPARE, 8'h5A);
        push_pixel(8'h80, 1'b0);
        push_pixel(8'h7F, 1'b1);
        drain_frames();

        // low start above high start
        set_levels_cfg(1'b1, 1'b1, 8'd200, 8'd50, 7'd50);
        push_pixel(255, 1'b0);
        push_pixel(0, 1'b0);
        push_pixel(200, 1'b1);
        drain_frames();

        // zero threshold: nothing may be cut
        set_levels_cfg(1'b0, 1'b1, 8'd255, 8'd0, 7'd0);
        push_pixel(0, 1'b0);
        push_pixel(255, 1'b1);
        push_pixel(3, 1'b0);
        push_pixel(3, 1'b0);
        push_pixel(3, 1'b0);
        push_pixel(252, 1'b1);
        drain_frames();

        // full threshold with remap off, then remap on but auto off
        set_levels_cfg(1'b0, 1'b1, 8'd0, 8'd0, 7'd100);
        push_pixel(1, 1'b0);
        push_pixel(2, 1'b0);
        push_pixel(3, 1'b0);
        push_pixel(4, 1'b1);
        drain_frames();
        set_levels_cfg(1'b1, 1'b0, 8'd37, 8'd201, 7'd5);
        push_pixel(9, 1'b1);
        drain_frames();

        // random phases, one without idling and one with a long output hold-off
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_cfg();
            gaps_on = (p != 2);
            if (p == 5)
                hold_req = 1'b1;
            phase_pix = 0;
            while (phase_pix < PHASE_PIXELS)
            begin
                push_random_frame(npix);
                phase_pix += npix;
            end
            drain_frames();
        end

        if (levels_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived, next expected low %0d high %0d",
                     $time, levels_due.size(), levels_due[0].low, levels_due[0].high);
            fail_count++;
        end
        $display("Covered %0d pixels in %0d frames over %0d register settings,",
                 pixels_sent, frames_queued, cfg_settings);
        $display("with thresholds 0, 100 and 127, inverted start levels and a held-off output.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
